[rtl/rvimm_pkg.sv]
// Shared types and constants for the RV32I immediate/load execute block.
`timescale 1ns / 1ps

package rvimm_pkg;

    // Data memory geometry: byte-addressed, split into four byte banks.
    // MEM_BYTES must be a power of two and a multiple of BANKS.
    localparam int MEM_BYTES = 4096;
    localparam int MEM_AW    = $clog2(MEM_BYTES);
    localparam int BANKS     = 4;
    localparam int BANK_W    = $clog2(BANKS);
    localparam int ROWS      = MEM_BYTES / BANKS;
    localparam int ROW_W     = $clog2(ROWS);

    localparam int XLEN      = 32;
    localparam int NREGS     = 32;
    localparam int REG_W     = $clog2(NREGS);

    // Link offset for JALR.
    localparam logic [XLEN-1:0] PC_STEP = 32'd4;

    // Command codes as they arrive on the cmd port.
    typedef enum logic [3:0] {
        CMD_ADDI    = 4'd0,
        CMD_ANDI    = 4'd1,
        CMD_JALR    = 4'd2,
        CMD_LB      = 4'd3,
        CMD_LBU     = 4'd4,
        CMD_LH      = 4'd5,
        CMD_LHU     = 4'd6,
        CMD_LW      = 4'd7,
        CMD_ORI     = 4'd8,
        CMD_SLLI    = 4'd9,
        CMD_SLTI    = 4'd10,
        CMD_SLTIU   = 4'd11,
        CMD_SRAI    = 4'd12,
        CMD_SRLI    = 4'd13,
        CMD_XORI    = 4'd14,
        CMD_PRELOAD = 4'd15
    } cmd_t;

    // Operation the back end performs for non-load instructions.
    typedef enum logic [3:0] {
        ALU_ADD,
        ALU_AND,
        ALU_OR,
        ALU_XOR,
        ALU_SLT,
        ALU_SLTU,
        ALU_SLL,
        ALU_SRL,
        ALU_SRA,
        ALU_LINK,
        ALU_NONE
    } alu_op_t;

    typedef enum logic [1:0] {
        LD_BYTE,
        LD_HALF,
        LD_WORD
    } ld_size_t;

    // Classified instruction, as held in the queue between front and back.
    typedef struct packed {
        alu_op_t           op;
        logic              is_load;
        ld_size_t          ld_size;
        logic              ld_signed;
        logic              is_jalr;
        logic              is_preload;
        logic              wr;        // writes a nonzero rd
        logic [REG_W-1:0]  rd;
        logic [REG_W-1:0]  rs;
        logic [XLEN-1:0]   imm;
        logic [MEM_AW-1:0] pl_addr;
        logic [7:0]        pl_byte;
    } dec_t;

endpackage

[rtl/rvimm_front.sv]
// Front end: input handshake and instruction classification.
`timescale 1ns / 1ps

module rvimm_front (
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [3:0]               cmd,
    input  logic [4:0]               dest_index,
    input  logic [4:0]               src_index,
    input  logic signed [11:0]       immediate,
    input  logic [11:0]              preload_addr,
    input  logic [7:0]               preload_byte,
    input  logic                     q_full,
    input  logic                     mem_ready,
    output logic                     push,
    output rvimm_pkg::dec_t          push_item
);

    // Accept only when the queue has room and the memory clear is done
    assign in_ready = !q_full && mem_ready;
    assign push     = in_valid && in_ready;

    // Decode the command into an operation class
    always_comb
    begin
        push_item            = '0;
        push_item.op         = rvimm_pkg::ALU_NONE;
        push_item.ld_size    = rvimm_pkg::LD_WORD;
        push_item.rd         = dest_index;
        push_item.rs         = src_index;
        push_item.imm        = {{(rvimm_pkg::XLEN-12){immediate[11]}}, immediate};
        push_item.pl_addr    = preload_addr[rvimm_pkg::MEM_AW-1:0];
        push_item.pl_byte    = preload_byte;
        push_item.wr         = (dest_index != '0);

        case (rvimm_pkg::cmd_t'(cmd))
            rvimm_pkg::CMD_ADDI:  push_item.op = rvimm_pkg::ALU_ADD;
            rvimm_pkg::CMD_ANDI:  push_item.op = rvimm_pkg::ALU_AND;
            rvimm_pkg::CMD_ORI:   push_item.op = rvimm_pkg::ALU_OR;
            rvimm_pkg::CMD_XORI:  push_item.op = rvimm_pkg::ALU_XOR;
            rvimm_pkg::CMD_SLTI:  push_item.op = rvimm_pkg::ALU_SLT;
            rvimm_pkg::CMD_SLTIU: push_item.op = rvimm_pkg::ALU_SLTU;
            rvimm_pkg::CMD_SLLI:  push_item.op = rvimm_pkg::ALU_SLL;
            rvimm_pkg::CMD_SRLI:  push_item.op = rvimm_pkg::ALU_SRL;
            rvimm_pkg::CMD_SRAI:  push_item.op = rvimm_pkg::ALU_SRA;
            rvimm_pkg::CMD_JALR:
            begin
                push_item.op      = rvimm_pkg::ALU_LINK;
                push_item.is_jalr = 1'b1;
            end
            rvimm_pkg::CMD_LB:
            begin
                push_item.is_load   = 1'b1;
                push_item.ld_size   = rvimm_pkg::LD_BYTE;
                push_item.ld_signed = 1'b1;
            end
            rvimm_pkg::CMD_LBU:
            begin
                push_item.is_load = 1'b1;
                push_item.ld_size = rvimm_pkg::LD_BYTE;
            end
            rvimm_pkg::CMD_LH:
            begin
                push_item.is_load   = 1'b1;
                push_item.ld_size   = rvimm_pkg::LD_HALF;
                push_item.ld_signed = 1'b1;
            end
            rvimm_pkg::CMD_LHU:
            begin
                push_item.is_load = 1'b1;
                push_item.ld_size = rvimm_pkg::LD_HALF;
            end
            rvimm_pkg::CMD_LW:
            begin
                push_item.is_load = 1'b1;
                push_item.ld_size = rvimm_pkg::LD_WORD;
            end
            rvimm_pkg::CMD_PRELOAD:
            begin
                push_item.is_preload = 1'b1;
                push_item.wr         = 1'b0;
            end
            default:
            begin
                push_item.op = rvimm_pkg::ALU_NONE;
                push_item.wr = 1'b0;
            end
        endcase
    end

endmodule

[rtl/rvimm_queue.sv]
// Two-entry queue of classified instructions between front and back end.
`timescale 1ns / 1ps

module rvimm_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  rvimm_pkg::dec_t  push_item,
    input  logic             pop,
    output logic             full,
    output logic             head_valid,
    output rvimm_pkg::dec_t  head_item
);

    rvimm_pkg::dec_t entry_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_item  = entry_reg[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

[rtl/rvimm_back.sv]
// Back end: register file, banked data memory, pc, execute and write-back.
`timescale 1ns / 1ps

module rvimm_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  rvimm_pkg::dec_t     head_item,
    output logic                pop,
    output logic                mem_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                reg_written,
    output logic [4:0]          written_index,
    output logic [31:0]         written_value,
    output logic [31:0]         next_pc
);

    localparam int XLEN   = rvimm_pkg::XLEN;
    localparam int MEM_AW = rvimm_pkg::MEM_AW;
    localparam int BANKS  = rvimm_pkg::BANKS;
    localparam int BANK_W = rvimm_pkg::BANK_W;
    localparam int ROW_W  = rvimm_pkg::ROW_W;
    localparam int ROWS   = rvimm_pkg::ROWS;
    localparam int REG_W  = rvimm_pkg::REG_W;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_EXEC,
        ST_WB
    } state_t;

    state_t                      state_reg;
    logic [ROW_W-1:0]            clr_cnt_reg;
    logic [XLEN-1:0]             rf_reg [rvimm_pkg::NREGS];
    logic [XLEN-1:0]             pc_reg;

    // Write-back stage registers
    logic                        wb_wr_reg;
    logic [REG_W-1:0]            wb_rd_reg;
    logic [XLEN-1:0]             wb_val_reg;
    logic                        wb_is_load_reg;
    rvimm_pkg::ld_size_t         wb_ld_size_reg;
    logic                        wb_ld_signed_reg;
    logic [BANK_W-1:0]           wb_lo_reg;
    logic                        wb_is_jalr_reg;
    logic [XLEN-1:0]             wb_target_reg;

    // Output slot
    logic                        out_valid_reg;
    logic                        out_wr_reg;
    logic [REG_W-1:0]            out_rd_reg;
    logic [XLEN-1:0]             out_val_reg;
    logic [XLEN-1:0]             out_pc_reg;

    logic                        exec_fire;
    logic                        wb_fire;
    logic [XLEN-1:0]             src_val;
    logic [XLEN-1:0]             sum;
    logic [4:0]                  shamt;
    logic [XLEN-1:0]             alu_next;
    logic [XLEN-1:0]             load_val;
    logic [XLEN-1:0]             wb_val_next;
    logic [XLEN-1:0]             pc_next;

    logic [BANKS-1:0]            bank_we;
    logic [ROW_W-1:0]            bank_waddr [BANKS];
    logic [7:0]                  bank_wdata [BANKS];
    logic [ROW_W-1:0]            bank_raddr [BANKS];
    logic [7:0]                  bank_rdata [BANKS];

    assign mem_ready = (state_reg != ST_CLEAR);
    assign exec_fire = (state_reg == ST_EXEC) && head_valid;
    assign pop       = exec_fire;
    assign wb_fire   = (state_reg == ST_WB) && (!out_valid_reg || out_ready);

    assign out_valid     = out_valid_reg;
    assign reg_written   = out_wr_reg;
    assign written_index = out_rd_reg;
    assign written_value = out_val_reg;
    assign next_pc       = out_pc_reg;

    // Operand read and effective address
    assign src_val = rf_reg[head_item.rs];
    assign sum     = src_val + head_item.imm;
    assign shamt   = head_item.imm[4:0];

    // Immediate ALU
    always_comb
    begin
        case (head_item.op)
            rvimm_pkg::ALU_ADD:  alu_next = sum;
            rvimm_pkg::ALU_AND:  alu_next = src_val & head_item.imm;
            rvimm_pkg::ALU_OR:   alu_next = src_val | head_item.imm;
            rvimm_pkg::ALU_XOR:  alu_next = src_val ^ head_item.imm;
            rvimm_pkg::ALU_SLT:
                alu_next = {{(XLEN-1){1'b0}},
                            ($signed(src_val) < $signed(head_item.imm))};
            rvimm_pkg::ALU_SLTU:
                alu_next = {{(XLEN-1){1'b0}}, (src_val < head_item.imm)};
            rvimm_pkg::ALU_SLL:  alu_next = src_val << shamt;
            rvimm_pkg::ALU_SRL:  alu_next = src_val >> shamt;
            rvimm_pkg::ALU_SRA:  alu_next = XLEN'($signed(src_val) >>> shamt);
            rvimm_pkg::ALU_LINK: alu_next = pc_reg + rvimm_pkg::PC_STEP;
            default:             alu_next = '0;
        endcase
    end

    // Per-bank ports: clear pass, preload write, load read of four bytes
    always_comb
    begin
        logic [BANK_W-1:0] ofs;
        logic [MEM_AW-1:0] baddr;
        for (int b = 0; b < BANKS; b++)
        begin
            ofs           = BANK_W'(b) - sum[BANK_W-1:0];
            baddr         = sum[MEM_AW-1:0] + {{(MEM_AW-BANK_W){1'b0}}, ofs};
            bank_raddr[b] = baddr[MEM_AW-1:BANK_W];
            if (state_reg == ST_CLEAR)
            begin
                bank_we[b]    = 1'b1;
                bank_waddr[b] = clr_cnt_reg;
                bank_wdata[b] = 8'd0;
            end
            else
            begin
                bank_we[b]    = exec_fire && head_item.is_preload
                                && (head_item.pl_addr[BANK_W-1:0] == BANK_W'(b));
                bank_waddr[b] = head_item.pl_addr[MEM_AW-1:BANK_W];
                bank_wdata[b] = head_item.pl_byte;
            end
        end
    end

    // Byte banks of the data memory
    for (genvar b = 0; b < BANKS; b++)
    begin : g_bank
        logic [7:0] mem [ROWS];

        always_ff @(posedge clk)
        begin
            if (bank_we[b])
                mem[bank_waddr[b]] <= bank_wdata[b];
            if (exec_fire)
                bank_rdata[b] <= mem[bank_raddr[b]];
        end
    end

    // Load data: reorder bytes from the banks, then extend
    always_comb
    begin
        logic [7:0]        byte_v [BANKS];
        logic [BANK_W-1:0] sel;
        for (int i = 0; i < BANKS; i++)
        begin
            sel       = wb_lo_reg + BANK_W'(i);
            byte_v[i] = bank_rdata[sel];
        end
        case (wb_ld_size_reg)
            rvimm_pkg::LD_BYTE:
                load_val = {{(XLEN-8){wb_ld_signed_reg & byte_v[0][7]}}, byte_v[0]};
            rvimm_pkg::LD_HALF:
                load_val = {{(XLEN-16){wb_ld_signed_reg & byte_v[1][7]}},
                            byte_v[1], byte_v[0]};
            default:
                load_val = {byte_v[3], byte_v[2], byte_v[1], byte_v[0]};
        endcase
    end

    assign wb_val_next = wb_is_load_reg ? load_val : wb_val_reg;
    assign pc_next     = wb_is_jalr_reg ? wb_target_reg : pc_reg;

    // Sequencer, register file, pc, stage and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_cnt_reg      <= '0;
            pc_reg           <= '0;
            for (int r = 0; r < rvimm_pkg::NREGS; r++)
                rf_reg[r] <= '0;
            wb_wr_reg        <= 1'b0;
            wb_rd_reg        <= '0;
            wb_val_reg       <= '0;
            wb_is_load_reg   <= 1'b0;
            wb_ld_size_reg   <= rvimm_pkg::LD_WORD;
            wb_ld_signed_reg <= 1'b0;
            wb_lo_reg        <= '0;
            wb_is_jalr_reg   <= 1'b0;
            wb_target_reg    <= '0;
            out_valid_reg    <= 1'b0;
            out_wr_reg       <= 1'b0;
            out_rd_reg       <= '0;
            out_val_reg      <= '0;
            out_pc_reg       <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + ROW_W'(1);
                    if (clr_cnt_reg == ROW_W'(ROWS - 1))
                        state_reg <= ST_EXEC;
                end
                ST_EXEC:
                begin
                    if (exec_fire)
                    begin
                        wb_wr_reg        <= head_item.wr;
                        wb_rd_reg        <= head_item.rd;
                        wb_val_reg       <= alu_next;
                        wb_is_load_reg   <= head_item.is_load;
                        wb_ld_size_reg   <= head_item.ld_size;
                        wb_ld_signed_reg <= head_item.ld_signed;
                        wb_lo_reg        <= sum[BANK_W-1:0];
                        wb_is_jalr_reg   <= head_item.is_jalr;
                        wb_target_reg    <= {sum[XLEN-1:1], 1'b0};
                        state_reg        <= ST_WB;
                    end
                end
                ST_WB:
                begin
                    if (wb_fire)
                    begin
                        if (wb_wr_reg)
                            rf_reg[wb_rd_reg] <= wb_val_next;
                        pc_reg        <= pc_next;
                        out_valid_reg <= 1'b1;
                        out_wr_reg    <= wb_wr_reg;
                        out_rd_reg    <= wb_wr_reg ? wb_rd_reg : '0;
                        out_val_reg   <= wb_wr_reg ? wb_val_next : '0;
                        out_pc_reg    <= pc_next;
                        state_reg     <= ST_EXEC;
                    end
                end
                default:
                    state_reg <= ST_EXEC;
            endcase
        end
    end

endmodule

[rtl/rv32i_immediate_and_load_exec.sv]
// Top level: RV32I I-type and load execute block with byte preload.
// An input beat passes the queue, then execute, then write-back before output valid.
// The back end takes one instruction at a time: execute does the register-file and
//   memory-bank read, write-back the register write, which waits on a full output slot.
// Reset: registers and pc clear at once; the data memory is then swept to zero,
//   one row of four banks per cycle, over all 1024 rows with in_ready low.
`timescale 1ns / 1ps

module rv32i_immediate_and_load_exec (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [3:0]         cmd,
    input  logic [4:0]         dest_index,
    input  logic [4:0]         src_index,
    input  logic signed [11:0] immediate,
    input  logic [11:0]        preload_addr,
    input  logic [7:0]         preload_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               reg_written,
    output logic [4:0]         written_index,
    output logic [31:0]        written_value,
    output logic [31:0]        next_pc
);

    logic            q_full;
    logic            mem_ready;
    logic            push;
    logic            pop;
    logic            head_valid;
    rvimm_pkg::dec_t push_item;
    rvimm_pkg::dec_t head_item;

    // Accept and classify
    rvimm_front u_front (
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .dest_index   (dest_index),
        .src_index    (src_index),
        .immediate    (immediate),
        .preload_addr (preload_addr),
        .preload_byte (preload_byte),
        .q_full       (q_full),
        .mem_ready    (mem_ready),
        .push         (push),
        .push_item    (push_item)
    );

    // Decoupling queue
    rvimm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // Execute and write back
    rvimm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_item     (head_item),
        .pop           (pop),
        .mem_ready     (mem_ready),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .reg_written   (reg_written),
        .written_index (written_index),
        .written_value (written_value),
        .next_pc       (next_pc)
    );

endmodule

[tb/sv/rv32i_immediate_and_load_exec_tb.sv]
// Self-checking testbench for the RV32I I-type and load execute block.
`timescale 1ns / 1ps

// Tracks architectural state and compares every result beat in order
class exec_scoreboard;
    typedef struct {
        logic        wr;
        logic [4:0]  idx;
        logic [31:0] val;
        logic [31:0] pc;
    } exec_result_t;

    logic [31:0]  regs [rvimm_pkg::NREGS];
    logic [7:0]   mem [rvimm_pkg::MEM_BYTES];
    logic [31:0]  pc;
    exec_result_t expected_results [$];
    int           errors;
    int           checked;
    int           n_items;
    int           n_loads;
    int           n_preloads;
    int           n_jumps;

    function new();
        foreach (regs[i]) regs[i] = '0;
        foreach (mem[i]) mem[i] = '0;
        pc         = '0;
        errors     = 0;
        checked    = 0;
        n_items    = 0;
        n_loads    = 0;
        n_preloads = 0;
        n_jumps    = 0;
    endfunction

    // Apply one accepted input beat to the state and queue its result
    function void execute_instr(rvimm_pkg::cmd_t op, logic [4:0] rd, logic [4:0] rs,
                                logic [11:0] imm, logic [11:0] pa, logic [7:0] pb);
        logic [31:0]  a;
        logic [31:0]  immx;
        logic [4:0]   sh;
        logic [31:0]  val;
        logic [31:0]  addr;
        logic [31:0]  raw;
        logic         wr;
        int           nbytes;
        exec_result_t res;

        a      = regs[rs];
        immx   = {{20{imm[11]}}, imm};
        sh     = immx[4:0];
        val    = '0;
        wr     = 1'b1;
        addr   = a + immx;
        raw    = '0;
        nbytes = 0;
        n_items++;

        // gather load bytes little-endian, wrapping on the memory size
        case (op)
            rvimm_pkg::CMD_LB, rvimm_pkg::CMD_LBU: nbytes = 1;
            rvimm_pkg::CMD_LH, rvimm_pkg::CMD_LHU: nbytes = 2;
            rvimm_pkg::CMD_LW:                     nbytes = 4;
            default:                               nbytes = 0;
        endcase
        for (int i = 0; i < nbytes; i++)
            raw[8*i +: 8] = mem[(addr + i) % rvimm_pkg::MEM_BYTES];
        if (nbytes != 0)
            n_loads++;

        case (op)
            rvimm_pkg::CMD_ADDI:  val = a + immx;
            rvimm_pkg::CMD_ANDI:  val = a & immx;
            rvimm_pkg::CMD_ORI:   val = a | immx;
            rvimm_pkg::CMD_XORI:  val = a ^ immx;
            rvimm_pkg::CMD_SLTI:  val = ($signed(a) < $signed(immx)) ? 32'd1 : 32'd0;
            rvimm_pkg::CMD_SLTIU: val = (a < immx) ? 32'd1 : 32'd0;
            rvimm_pkg::CMD_SLLI:  val = a << sh;
            rvimm_pkg::CMD_SRLI:  val = a >> sh;
            rvimm_pkg::CMD_SRAI:  val = $unsigned($signed(a) >>> sh);
            rvimm_pkg::CMD_JALR:
            begin
                val = pc + 32'd4;
                pc  = addr & ~32'd1;
                n_jumps++;
            end
            rvimm_pkg::CMD_LB:    val = {{24{raw[7]}}, raw[7:0]};
            rvimm_pkg::CMD_LBU:   val = {24'd0, raw[7:0]};
            rvimm_pkg::CMD_LH:    val = {{16{raw[15]}}, raw[15:0]};
            rvimm_pkg::CMD_LHU:   val = {16'd0, raw[15:0]};
            rvimm_pkg::CMD_LW:    val = raw;
            default:
            begin
                mem[pa % rvimm_pkg::MEM_BYTES] = pb;
                wr = 1'b0;
                n_preloads++;
            end
        endcase

        // x0 never takes a write
        if (wr && rd != 5'd0)
        begin
            regs[rd] = val;
            res = '{1'b1, rd, val, pc};
        end
        else
        begin
            res = '{1'b0, 5'd0, 32'd0, pc};
        end
        expected_results.push_back(res);
    endfunction

    // Compare one result beat against the oldest expectation
    function void check_result(logic wr, logic [4:0] idx, logic [31:0] val, logic [31:0] npc);
        exec_result_t want;

        if (expected_results.size() == 0)
        begin
            $error("result beat with nothing expected: reg_written %0d index %0d value %h pc %h",
                   wr, idx, val, npc);
            errors++;
            return;
        end
        want = expected_results.pop_front();
        checked++;
        if (wr !== want.wr)
        begin
            $error("reg_written: expected %0d, actual %0d", want.wr, wr);
            errors++;
        end
        if (idx !== want.idx)
        begin
            $error("written_index: expected %0d, actual %0d", want.idx, idx);
            errors++;
        end
        if (val !== want.val)
        begin
            $error("written_value: expected %h, actual %h", want.val, val);
            errors++;
        end
        if (npc !== want.pc)
        begin
            $error("next_pc: expected %h, actual %h", want.pc, npc);
            errors++;
        end
    endfunction
endclass

module rv32i_immediate_and_load_exec_tb;

    localparam int N_TOTAL     = 850;
    localparam int QUIET_TAIL  = 100;
    localparam int CYCLE_LIMIT = 200000;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            in_valid = 1'b0;
    logic            in_ready;
    rvimm_pkg::cmd_t cmd = rvimm_pkg::CMD_ADDI;
    logic [4:0]      dest_index = '0;
    logic [4:0]      src_index = '0;
    logic [11:0]     immediate = '0;
    logic [11:0]     preload_addr = '0;
    logic [7:0]      preload_byte = '0;
    logic            out_valid;
    logic            out_ready = 1'b0;
    logic            reg_written;
    logic [4:0]      written_index;
    logic [31:0]     written_value;
    logic [31:0]     next_pc;

    logic           idle_on = 1'b1;
    int             cycle_count = 0;
    exec_scoreboard sb = new();

    rv32i_immediate_and_load_exec u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .dest_index    (dest_index),
        .src_index     (src_index),
        .immediate     (immediate),
        .preload_addr  (preload_addr),
        .preload_byte  (preload_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .reg_written   (reg_written),
        .written_index (written_index),
        .written_value (written_value),
        .next_pc       (next_pc)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Drive one input beat, hold it until accepted, then update the prediction
    task automatic send_item(rvimm_pkg::cmd_t op, logic [4:0] rd, logic [4:0] rs,
                             logic [11:0] imm, logic [11:0] pa, logic [7:0] pb);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        cmd          <= op;
        dest_index   <= rd;
        src_index    <= rs;
        immediate    <= imm;
        preload_addr <= pa;
        preload_byte <= pb;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.execute_instr(op, rd, rs, imm, pa, pb);
    endtask

    // Instruction with random values on the unused preload fields
    task automatic send_instr(rvimm_pkg::cmd_t op, logic [4:0] rd, logic [4:0] rs,
                              logic [11:0] imm);
        send_item(op, rd, rs, imm, 12'($urandom), 8'($urandom));
    endtask

    // Preload with random values on the unused instruction fields
    task automatic preload_at(logic [11:0] pa, logic [7:0] pb);
        send_item(rvimm_pkg::CMD_PRELOAD, 5'($urandom), 5'($urandom), 12'($urandom), pa, pb);
    endtask

    // Seed bytes at the address a load will hit, then issue the load
    task automatic load_sequence();
        logic [4:0]      base_reg;
        logic [11:0]     off;
        logic [31:0]     target;
        rvimm_pkg::cmd_t op;

        base_reg = 5'($urandom_range(0, 31));
        if (base_reg != 5'd0 && $urandom_range(0, 1) == 1)
            send_instr(rvimm_pkg::CMD_ADDI, base_reg, 5'd0, 12'($urandom));
        off    = 12'($urandom);
        target = sb.regs[base_reg] + {{20{off[11]}}, off};
        repeat ($urandom_range(1, 4))
        begin
            preload_at(12'(target % rvimm_pkg::MEM_BYTES), 8'($urandom));
            target = target + 32'd1;
        end
        case ($urandom_range(0, 4))
            0:       op = rvimm_pkg::CMD_LB;
            1:       op = rvimm_pkg::CMD_LBU;
            2:       op = rvimm_pkg::CMD_LH;
            3:       op = rvimm_pkg::CMD_LHU;
            default: op = rvimm_pkg::CMD_LW;
        endcase
        send_instr(op, 5'($urandom), base_reg, off);
    endtask

    // Arithmetic, logic, shift, compare or jump with random operands
    task automatic alu_item();
        rvimm_pkg::cmd_t op;

        case ($urandom_range(0, 9))
            0:       op = rvimm_pkg::CMD_ADDI;
            1:       op = rvimm_pkg::CMD_ANDI;
            2:       op = rvimm_pkg::CMD_ORI;
            3:       op = rvimm_pkg::CMD_XORI;
            4:       op = rvimm_pkg::CMD_SLTI;
            5:       op = rvimm_pkg::CMD_SLTIU;
            6:       op = rvimm_pkg::CMD_SLLI;
            7:       op = rvimm_pkg::CMD_SRLI;
            8:       op = rvimm_pkg::CMD_SRAI;
            default: op = rvimm_pkg::CMD_JALR;
        endcase
        send_instr(op, 5'($urandom), 5'($urandom), 12'($urandom));
    endtask

    // Output side: random stall bursts while idling is enabled
    initial
    begin : ready_gen
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (idle_on && stall_left == 0 && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 5);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Check every accepted result beat
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(reg_written, written_index, written_value, next_pc);
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, sb.expected_results.size());
        $display("** rv32i_immediate_and_load_exec: FAILED **");
        $finish;
    end

    // Main sequence
    initial
    begin
        int next_switch;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: operand extremes, x0 discard, shift masking, wrap-around loads, jumps
        send_instr(rvimm_pkg::CMD_ADDI,  5'd1,  5'd0,  12'h800);
        send_instr(rvimm_pkg::CMD_ADDI,  5'd2,  5'd0,  12'h7FF);
        send_instr(rvimm_pkg::CMD_ADDI,  5'd0,  5'd1,  12'h005);
        send_instr(rvimm_pkg::CMD_ORI,   5'd3,  5'd1,  12'h555);
        send_instr(rvimm_pkg::CMD_XORI,  5'd4,  5'd2,  12'hFFF);
        send_instr(rvimm_pkg::CMD_ANDI,  5'd5,  5'd1,  12'h7F0);
        send_instr(rvimm_pkg::CMD_SLLI,  5'd6,  5'd2,  12'h01F);
        send_instr(rvimm_pkg::CMD_SLLI,  5'd6,  5'd1,  12'h7E5);
        send_instr(rvimm_pkg::CMD_SRLI,  5'd7,  5'd1,  12'h004);
        send_instr(rvimm_pkg::CMD_SRAI,  5'd8,  5'd1,  12'h004);
        send_instr(rvimm_pkg::CMD_SRAI,  5'd8,  5'd2,  12'hFFF);
        send_instr(rvimm_pkg::CMD_SLTI,  5'd9,  5'd1,  12'h000);
        send_instr(rvimm_pkg::CMD_SLTI,  5'd9,  5'd2,  12'hFFF);
        send_instr(rvimm_pkg::CMD_SLTIU, 5'd10, 5'd2,  12'hFFF);
        send_instr(rvimm_pkg::CMD_SLTIU, 5'd10, 5'd1,  12'h001);
        preload_at(12'h000, 8'h80);
        preload_at(12'h001, 8'hFF);
        preload_at(12'hFFF, 8'h12);
        preload_at(12'hFFE, 8'h34);
        send_instr(rvimm_pkg::CMD_LB,    5'd11, 5'd0,  12'h000);
        send_instr(rvimm_pkg::CMD_LBU,   5'd12, 5'd0,  12'h000);
        send_instr(rvimm_pkg::CMD_LH,    5'd13, 5'd2,  12'h800);
        send_instr(rvimm_pkg::CMD_LHU,   5'd14, 5'd2,  12'h800);
        send_instr(rvimm_pkg::CMD_LW,    5'd31, 5'd0,  12'hFFE);
        send_instr(rvimm_pkg::CMD_JALR,  5'd15, 5'd2,  12'h001);
        send_instr(rvimm_pkg::CMD_JALR,  5'd0,  5'd1,  12'h003);
        send_instr(rvimm_pkg::CMD_JALR,  5'd15, 5'd15, 12'h000);

        // random: mostly seeded load sequences and ALU work, some raw noise
        next_switch = sb.n_items;
        while (sb.n_items < N_TOTAL)
        begin
            if (sb.n_items >= N_TOTAL - QUIET_TAIL)
            begin
                idle_on = 1'b0;
            end
            else if (sb.n_items >= next_switch)
            begin
                idle_on     = ($urandom_range(0, 2) != 0);
                next_switch = sb.n_items + 80;
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3: load_sequence();
                4, 5, 6:    alu_item();
                default:    send_item(rvimm_pkg::cmd_t'($urandom_range(0, 15)),
                                      5'($urandom), 5'($urandom), 12'($urandom),
                                      12'($urandom), 8'($urandom));
            endcase
        end
        in_valid <= 1'b0;

        // drain, then give stray beats a chance to show up
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Executed %0d beats: %0d loads, %0d preloads, %0d jumps, rest ALU ops.",
                 sb.n_items, sb.n_loads, sb.n_preloads, sb.n_jumps);
        $display("Compared %0d results, %0d field mismatches.", sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("** rv32i_immediate_and_load_exec: PASSED **");
        else
            $display("** rv32i_immediate_and_load_exec: FAILED **");
        $finish;
    end

endmodule
